// File: src/lfu_pkg.sv
// Shared types and constants for the LFU cache table.
// No dependencies; compiled first.
package lfu_pkg;

  localparam int KEY_W = 31;
  localparam int VAL_W = 31;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

endpackage

// File: src/lfu_req_if.sv
// Request channel of the LFU cache table: valid/ready plus op, key, value.
// Depends on lfu_pkg.
interface lfu_req_if;
  import lfu_pkg::*;

  logic             valid;
  logic             ready;
  op_t              op;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;

  modport source (output valid, output op, output key, output value, input ready);
  modport sink   (input valid, input op, input key, input value, output ready);
endinterface

// File: src/lfu_rsp_if.sv
// Result channel of the LFU cache table: valid/ready plus lookup and eviction info.
// Depends on lfu_pkg.
interface lfu_rsp_if;
  import lfu_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [VAL_W-1:0] read_value;
  logic             evicted;
  logic [KEY_W-1:0] evicted_key;

  modport source (output valid, output found, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input found, input read_value, input evicted,
                  input evicted_key, output ready);
endinterface

// File: src/lfu_victim.sv
// Eviction candidate search: least use count, ties to the oldest recency rank.
// Pairwise reduction tree over all entries; depends on nothing else.
module lfu_victim #(
  parameter int MAX_ENTRIES = 16,
  parameter int COUNT_BITS  = 16,
  parameter int IDX_W       = 4
) (
  input  logic [MAX_ENTRIES-1:0] valid,
  input  logic [COUNT_BITS-1:0]  count [MAX_ENTRIES],
  input  logic [IDX_W-1:0]       rank  [MAX_ENTRIES],
  output logic                   vic_found,
  output logic [IDX_W-1:0]       vic_idx
);
  localparam int LV  = IDX_W;
  localparam int NP  = 1 << LV;
  localparam int KW  = COUNT_BITS + IDX_W;

  logic             c_vld [LV+1][NP];
  logic [KW-1:0]    c_key [LV+1][NP];
  logic [IDX_W-1:0] c_idx [LV+1][NP];

  always_comb begin
    for (int l = 0; l <= LV; l++) begin
      for (int j = 0; j < NP; j++) begin
        c_vld[l][j] = 1'b0;
        c_key[l][j] = '0;
        c_idx[l][j] = '0;
      end
    end
    // leaves: lower key wins; inverted rank makes the older entry smaller
    for (int j = 0; j < NP; j++) begin
      if (j < MAX_ENTRIES) begin
        c_vld[0][j] = valid[j];
        c_key[0][j] = {count[j], ~rank[j]};
        c_idx[0][j] = IDX_W'(j);
      end
    end
    for (int l = 0; l < LV; l++) begin
      for (int j = 0; j < (NP >> (l + 1)); j++) begin
        if (c_vld[l][2*j+1] &&
            (!c_vld[l][2*j] || (c_key[l][2*j+1] < c_key[l][2*j]))) begin
          c_vld[l+1][j] = 1'b1;
          c_key[l+1][j] = c_key[l][2*j+1];
          c_idx[l+1][j] = c_idx[l][2*j+1];
        end else begin
          c_vld[l+1][j] = c_vld[l][2*j];
          c_key[l+1][j] = c_key[l][2*j];
          c_idx[l+1][j] = c_idx[l][2*j];
        end
      end
    end
  end

  assign vic_found = c_vld[LV][0];
  assign vic_idx   = c_idx[LV][0];

endmodule

// File: src/lfu_cache_table.sv
// LFU cache table with LRU tie-break: top level.
// Depends on lfu_pkg, lfu_req_if, lfu_rsp_if and lfu_victim.
//
// Usage:
//   in_ch  carries requests (op get/put, key, value) with valid/ready.
//   out_ch carries one result per request: found, read_value, evicted,
//          evicted_key, with valid/ready.
//   cfg_we/cfg_wdata write the capacity register; write it only while no
//   request is in flight.
// Timing:
//   A request sits in an input register, is resolved against the entry
//   table (parallel key compare, saturating count update, rank shift,
//   min-count/oldest-rank search) and lands in the result register.
//   out_ch.valid is driven by the result register, so a result passes the
//   input and result registers in that order; while out_ch.ready stays high,
//   one request per cycle is sustained, as the table update is combinational.
// Reset: all entries invalid, capacity 16, both pipeline registers empty.
// Stall: while the result is not taken, one more request is held in the
//   input register and in_ch.ready drops; no request is lost or dropped.
module lfu_cache_table #(
  parameter int MAX_ENTRIES = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [lfu_pkg::CAP_W-1:0]  cfg_wdata,
  lfu_req_if.sink                    in_ch,
  lfu_rsp_if.source                  out_ch
);
  import lfu_pkg::*;

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int USED_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W  = (USED_W > CAP_W) ? USED_W : CAP_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_ENTRIES);

  // configuration
  logic [CAP_W-1:0] cap_r;

  // entry table
  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt;
  logic [KEY_W-1:0]       key_r   [MAX_ENTRIES];
  logic [KEY_W-1:0]       key_nxt [MAX_ENTRIES];
  logic [VAL_W-1:0]       val_r   [MAX_ENTRIES];
  logic [VAL_W-1:0]       val_nxt [MAX_ENTRIES];
  logic [COUNT_BITS-1:0]  cnt_r   [MAX_ENTRIES];
  logic [COUNT_BITS-1:0]  cnt_nxt [MAX_ENTRIES];
  logic [IDX_W-1:0]       rank_r  [MAX_ENTRIES];
  logic [IDX_W-1:0]       rank_nxt[MAX_ENTRIES];
  logic [USED_W-1:0]      used_r, used_nxt;

  // input register
  logic             s_vld_r;
  op_t              s_op_r;
  logic [KEY_W-1:0] s_key_r;
  logic [VAL_W-1:0] s_val_r;

  // result register
  logic             o_vld_r;
  logic             o_found_r,  o_found_nxt;
  logic [VAL_W-1:0] o_rdval_r,  o_rdval_nxt;
  logic             o_evict_r,  o_evict_nxt;
  logic [KEY_W-1:0] o_evkey_r,  o_evkey_nxt;

  logic                   fire;
  logic [MAX_ENTRIES-1:0] hit;
  logic                   found;
  logic [IDX_W-1:0]       hit_idx;
  logic [VAL_W-1:0]       hit_val;
  logic [IDX_W-1:0]       hit_rank;
  logic [CMP_W-1:0]       cap_ext, cap_eff;
  logic                   cap_zero, full, is_put;
  logic                   do_touch, do_ins, do_evict, do_place;
  logic                   vic_found;
  logic [IDX_W-1:0]       vic_idx;
  logic [IDX_W-1:0]       vic_rank;
  logic [MAX_ENTRIES-1:0] valid_after;
  logic [IDX_W-1:0]       slot_idx;
  logic                   slot_ok;

  lfu_victim #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .COUNT_BITS  (COUNT_BITS),
    .IDX_W       (IDX_W)
  ) u_victim (
    .valid     (valid_r),
    .count     (cnt_r),
    .rank      (rank_r),
    .vic_found (vic_found),
    .vic_idx   (vic_idx)
  );

  assign fire        = s_vld_r && (!o_vld_r || out_ch.ready);
  assign in_ch.ready = !s_vld_r || fire;

  assign out_ch.valid       = o_vld_r;
  assign out_ch.found       = o_found_r;
  assign out_ch.read_value  = o_rdval_r;
  assign out_ch.evicted     = o_evict_r;
  assign out_ch.evicted_key = o_evkey_r;

  // lookup
  always_comb begin
    hit_idx = '0;
    hit_val = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit[i] = valid_r[i] && (key_r[i] == s_key_r);
    end
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_idx = IDX_W'(i);
        hit_val = val_r[i];
      end
    end
  end

  assign found    = |hit;
  assign hit_rank = rank_r[hit_idx];
  assign vic_rank = rank_r[vic_idx];

  assign cap_ext  = CMP_W'(cap_r);
  assign cap_eff  = (cap_ext > MAX_CMP) ? MAX_CMP : cap_ext;
  assign cap_zero = (cap_eff == '0);
  assign full     = (CMP_W'(used_r) >= cap_eff);
  assign is_put   = (s_op_r == OP_PUT);

  assign do_touch = found && (!is_put || !cap_zero);
  assign do_ins   = is_put && !found && !cap_zero;
  assign do_evict = do_ins && full && vic_found;

  // free slot after a possible eviction: lowest invalid entry
  always_comb begin
    valid_after = valid_r;
    if (do_evict) begin
      valid_after[vic_idx] = 1'b0;
    end
    slot_idx = '0;
    slot_ok  = 1'b0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_after[i]) begin
        slot_idx = IDX_W'(i);
        slot_ok  = 1'b1;
      end
    end
  end

  assign do_place = do_ins && slot_ok;

  // table update
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    cnt_nxt   = cnt_r;
    rank_nxt  = rank_r;
    used_nxt  = used_r;
    if (fire && do_touch) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (valid_r[i] && (rank_r[i] < hit_rank)) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
      rank_nxt[hit_idx] = '0;
      if (cnt_r[hit_idx] != {COUNT_BITS{1'b1}}) begin
        cnt_nxt[hit_idx] = cnt_r[hit_idx] + 1'b1;
      end
      if (is_put) begin
        val_nxt[hit_idx] = s_val_r;
      end
    end else if (fire && do_ins) begin
      valid_nxt = valid_after;
      // close the gap left by the victim, then age everyone by one
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (valid_after[i]) begin
          rank_nxt[i] = rank_r[i] - IDX_W'(do_evict && (rank_r[i] > vic_rank))
                                   + IDX_W'(do_place);
        end
      end
      if (do_place) begin
        valid_nxt[slot_idx] = 1'b1;
        key_nxt[slot_idx]   = s_key_r;
        val_nxt[slot_idx]   = s_val_r;
        cnt_nxt[slot_idx]   = COUNT_BITS'(1);
        rank_nxt[slot_idx]  = '0;
      end
      used_nxt = used_r - USED_W'(do_evict) + USED_W'(do_place);
    end
  end

  // result fields
  always_comb begin
    o_found_nxt = found;
    o_rdval_nxt = (!is_put && found) ? hit_val : '0;
    o_evict_nxt = do_evict;
    o_evkey_nxt = do_evict ? key_r[vic_idx] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      valid_r <= '0;
      used_r  <= '0;
      s_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      valid_r <= valid_nxt;
      used_r  <= used_nxt;
      if (in_ch.valid && in_ch.ready) begin
        s_vld_r <= 1'b1;
      end else if (fire) begin
        s_vld_r <= 1'b0;
      end
      if (fire) begin
        o_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        o_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    cnt_r  <= cnt_nxt;
    rank_r <= rank_nxt;
    if (in_ch.valid && in_ch.ready) begin
      s_op_r  <= in_ch.op;
      s_key_r <= in_ch.key;
      s_val_r <= in_ch.value;
    end
    if (fire) begin
      o_found_r <= o_found_nxt;
      o_rdval_r <= o_rdval_nxt;
      o_evict_r <= o_evict_nxt;
      o_evkey_r <= o_evkey_nxt;
    end
  end

`ifndef SYNTH
  a_used_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(used_r))
    else $error("entry count out of step with valid bits");

  a_key_unique: assert property (@(posedge clk) disable iff (!rst_n)
    s_vld_r |-> $onehot0(hit))
    else $error("key present in more than one entry");

  a_full_insert_evicts: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && do_ins && full) |-> vic_found)
    else $error("full table insert found no victim");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && do_ins && !full) |=> (used_r == $past(used_r) + 1'b1))
    else $error("insert into non-full table did not add an entry");
`endif

endmodule
